### rtl/route_time_window_evaluator_unit_defines.svh
// Assertion macros for the route time window evaluator.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef ROUTE_TIME_WINDOW_EVALUATOR_UNIT_DEFINES_SVH
`define ROUTE_TIME_WINDOW_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RTWE_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("route evaluator assertion failed");

// Next-cycle implication, disabled while in reset.
`define RTWE_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("route evaluator assertion failed");

`endif

### rtl/rtwe_pkg.sv
// Shared types and codes for the route time window evaluator.
// No dependencies; imported by all modules of the block.
package rtwe_pkg;

  typedef enum logic [1:0] {
    FAIL_NONE     = 2'd0,
    FAIL_DURATION = 2'd1,
    FAIL_WINDOW   = 2'd2,
    FAIL_CAPACITY = 2'd3
  } fail_t;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_OPEN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_CLOSE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_CAPACITY = 2'd3;

  // Outcome of one leg, including a failure latched on an earlier leg.
  typedef struct packed {
    logic  ok;
    fail_t reason;
  } leg_status_t;

endpackage

### rtl/route_time_window_evaluator_unit.sv
// Route time window evaluator: takes the legs of a vehicle route one transfer per
// clock and returns one result per route on the leg marked tlast. Each leg goes
// through an input register, one pass of leg evaluation (adds, compares, selects)
// into the route state and the result register, so a new leg is accepted every
// cycle. Only a last leg waits, and only while the previous result sits unread
// in the result register. Configuration writes are always accepted.
`include "route_time_window_evaluator_unit_defines.svh"

module route_time_window_evaluator_unit #(
  parameter int TIME_BITS = 24,
  parameter int LOAD_BITS = 16,
  localparam int InW       = 4 * TIME_BITS + LOAD_BITS,
  localparam int InTdataW  = ((InW + 7) / 8) * 8,
  localparam int OutW      = 5 * TIME_BITS + 2 + LOAD_BITS,
  localparam int OutTdataW = ((OutW + 7) / 8) * 8,
  localparam int CfgW      = (TIME_BITS > LOAD_BITS) ? TIME_BITS : LOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // leg_distance, prior_service, node_demand, window_open, window_close
  input  logic [InTdataW-1:0]            in_tdata,
  input  logic                           in_tlast,   // last_leg
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // depot_earliest_start, depot_latest_start, route duration, route distance,
  // wait_total, peak_load
  output logic [OutTdataW-1:0]           out_tdata,
  output logic [2:0]                     out_tuser,  // feasible, fail_reason
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CfgW-1:0]                cfg_wdata
);
  import rtwe_pkg::*;

  localparam int T = TIME_BITS;
  localparam int L = LOAD_BITS;

  // Configuration
  logic [T-1:0] depot_open;
  logic [T-1:0] depot_close;
  logic [T-1:0] max_duration;
  logic [L-1:0] vehicle_capacity;

  assign cfg_ready = 1'b1;

  rtwe_cfg_regs #(
    .TIME_BITS (TIME_BITS),
    .LOAD_BITS (LOAD_BITS),
    .CFG_W     (CfgW)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (cfg_valid && cfg_ready),
    .wr_index         (cfg_index),
    .wr_data          (cfg_wdata),
    .depot_open       (depot_open),
    .depot_close      (depot_close),
    .max_duration     (max_duration),
    .vehicle_capacity (vehicle_capacity)
  );

  // Input register
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic                s1_last_r;
  logic [T:0]          s1_time_r;
  logic [T-1:0]        s1_dist_r;
  logic signed [L-1:0] s1_demand_r;
  logic [T-1:0]        s1_wopen_r;
  logic [T-1:0]        s1_wclose_r;
  logic                in_xfer;
  logic                s1_adv;
  logic                out_free;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Travel plus service is folded before the register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last_r   <= in_tlast;
      s1_time_r   <= (T + 1)'(in_tdata[T-1:0]) + (T + 1)'(in_tdata[2*T-1:T]);
      s1_dist_r   <= in_tdata[T-1:0];
      s1_demand_r <= $signed(in_tdata[2*T+L-1:2*T]);
      s1_wopen_r  <= in_tdata[3*T+L-1:2*T+L];
      s1_wclose_r <= in_tdata[4*T+L-1:3*T+L];
    end
  end

  // Route state
  fail_t               fail_r;
  logic [T-1:0]        earliest_r;
  logic [T-1:0]        latest_r;
  logic [T-1:0]        duration_r;
  logic [T+1:0]        wait_r;
  logic [T-1:0]        distance_r;
  logic signed [L+1:0] load_r;
  logic [L-1:0]        peak_r;

  logic [T-1:0]        earliest_upd;
  logic [T-1:0]        latest_upd;
  logic [T-1:0]        duration_upd;
  logic [T+1:0]        wait_upd;
  logic [T-1:0]        distance_upd;
  logic signed [L+1:0] load_upd;
  logic [L-1:0]        peak_upd;
  leg_status_t         status;

  rtwe_leg_eval #(
    .TIME_BITS (TIME_BITS),
    .LOAD_BITS (LOAD_BITS)
  ) u_eval (
    .fail_in          (fail_r),
    .earliest         (earliest_r),
    .latest           (latest_r),
    .duration         (duration_r),
    .wait_acc         (wait_r),
    .distance         (distance_r),
    .load             (load_r),
    .peak             (peak_r),
    .leg_time         (s1_time_r),
    .leg_distance     (s1_dist_r),
    .node_demand      (s1_demand_r),
    .window_open      (s1_wopen_r),
    .window_close     (s1_wclose_r),
    .max_duration     (max_duration),
    .vehicle_capacity (vehicle_capacity),
    .earliest_upd     (earliest_upd),
    .latest_upd       (latest_upd),
    .duration_upd     (duration_upd),
    .wait_upd         (wait_upd),
    .distance_upd     (distance_upd),
    .load_upd         (load_upd),
    .peak_upd         (peak_upd),
    .status           (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_r     <= FAIL_NONE;
      earliest_r <= '0;
      latest_r   <= '1;
      duration_r <= '0;
      wait_r     <= '0;
      distance_r <= '0;
      load_r     <= '0;
      peak_r     <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // route done: reload depot values for the next route
        fail_r     <= FAIL_NONE;
        earliest_r <= depot_open;
        latest_r   <= depot_close;
        duration_r <= '0;
        wait_r     <= '0;
        distance_r <= '0;
        load_r     <= '0;
        peak_r     <= '0;
      end else begin
        fail_r <= status.reason;
        if (status.ok) begin
          earliest_r <= earliest_upd;
          latest_r   <= latest_upd;
          duration_r <= duration_upd;
          wait_r     <= wait_upd;
          distance_r <= distance_upd;
          load_r     <= load_upd;
          peak_r     <= peak_upd;
        end
      end
    end
  end

  // Result register
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         out_load;
  logic         out_feasible_r;
  fail_t        out_reason_r;
  logic [T:0]   out_est_r;
  logic [T:0]   out_lst_r;
  logic [T-1:0] out_dur_r;
  logic [T-1:0] out_dist_r;
  logic [T-1:0] out_wait_r;
  logic [L-1:0] out_peak_r;

  assign out_load = s1_adv && s1_last_r;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reason_r <= status.reason;
      if (status.ok) begin
        out_feasible_r <= 1'b1;
        out_est_r      <= {1'b0, earliest_upd} - {1'b0, duration_upd};
        out_lst_r      <= {1'b0, latest_upd} - {1'b0, duration_upd};
        out_dur_r      <= duration_upd;
        out_dist_r     <= distance_upd;
        out_wait_r     <= (wait_upd[T+1:T] != 2'b00) ? '1 : wait_upd[T-1:0];
        out_peak_r     <= peak_upd;
      end else begin
        out_feasible_r <= 1'b0;
        out_est_r      <= '0;
        out_lst_r      <= '0;
        out_dur_r      <= '0;
        out_dist_r     <= '0;
        out_wait_r     <= '0;
        out_peak_r     <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_reason_r, out_feasible_r};
  assign out_tdata  = OutTdataW'({out_peak_r, out_wait_r, out_dist_r, out_dur_r,
                                  out_lst_r, out_est_r});

  `RTWE_ASSERT_IMPL(a_feasible_matches_reason, out_tvalid, out_tuser[0] == (out_tuser[2:1] == FAIL_NONE))
  `RTWE_ASSERT_IMPL(a_failed_route_zero, out_tvalid && !out_tuser[0], out_tdata == '0)
  `RTWE_ASSERT_NEXT(a_route_restart, s1_adv && s1_last_r, (fail_r == FAIL_NONE) && (duration_r == '0))

endmodule

### rtl/rtwe_cfg_regs.sv
// Configuration register file: depot window, duration limit, capacity.
// Depends on rtwe_pkg for register indexes.
module rtwe_cfg_regs #(
  parameter int TIME_BITS = 24,
  parameter int LOAD_BITS = 16,
  parameter int CFG_W     = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [rtwe_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]               wr_data,
  output logic [TIME_BITS-1:0]           depot_open,
  output logic [TIME_BITS-1:0]           depot_close,
  output logic [TIME_BITS-1:0]           max_duration,
  output logic [LOAD_BITS-1:0]           vehicle_capacity
);
  import rtwe_pkg::*;

  logic [TIME_BITS-1:0] depot_open_r;
  logic [TIME_BITS-1:0] depot_close_r;
  logic [TIME_BITS-1:0] max_duration_r;
  logic [LOAD_BITS-1:0] capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depot_open_r   <= '0;
      depot_close_r  <= '1;
      max_duration_r <= '1;
      capacity_r     <= '1;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEPOT_OPEN:       depot_open_r   <= wr_data[TIME_BITS-1:0];
        CFG_DEPOT_CLOSE:      depot_close_r  <= wr_data[TIME_BITS-1:0];
        CFG_MAX_DURATION:     max_duration_r <= wr_data[TIME_BITS-1:0];
        CFG_VEHICLE_CAPACITY: capacity_r     <= wr_data[LOAD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign depot_open       = depot_open_r;
  assign depot_close      = depot_close_r;
  assign max_duration     = max_duration_r;
  assign vehicle_capacity = capacity_r;

endmodule

### rtl/rtwe_leg_eval.sv
// Combinational evaluation of one route leg against the running route state.
// Depends on rtwe_pkg for the failure codes and the leg status struct.
module rtwe_leg_eval #(
  parameter int TIME_BITS = 24,
  parameter int LOAD_BITS = 16
) (
  input  rtwe_pkg::fail_t              fail_in,
  input  logic [TIME_BITS-1:0]         earliest,
  input  logic [TIME_BITS-1:0]         latest,
  input  logic [TIME_BITS-1:0]         duration,
  input  logic [TIME_BITS+1:0]         wait_acc,
  input  logic [TIME_BITS-1:0]         distance,
  input  logic signed [LOAD_BITS+1:0]  load,
  input  logic [LOAD_BITS-1:0]         peak,
  input  logic [TIME_BITS:0]           leg_time,
  input  logic [TIME_BITS-1:0]         leg_distance,
  input  logic signed [LOAD_BITS-1:0]  node_demand,
  input  logic [TIME_BITS-1:0]         window_open,
  input  logic [TIME_BITS-1:0]         window_close,
  input  logic [TIME_BITS-1:0]         max_duration,
  input  logic [LOAD_BITS-1:0]         vehicle_capacity,
  output logic [TIME_BITS-1:0]         earliest_upd,
  output logic [TIME_BITS-1:0]         latest_upd,
  output logic [TIME_BITS-1:0]         duration_upd,
  output logic [TIME_BITS+1:0]         wait_upd,
  output logic [TIME_BITS-1:0]         distance_upd,
  output logic signed [LOAD_BITS+1:0]  load_upd,
  output logic [LOAD_BITS-1:0]         peak_upd,
  output rtwe_pkg::leg_status_t        status
);
  import rtwe_pkg::*;

  localparam int EW = TIME_BITS + 2;  // arrival sums
  localparam int DW = TIME_BITS + 3;  // signed duration / slack
  localparam int WW = TIME_BITS + 4;  // signed wait sum
  localparam int LW = LOAD_BITS + 3;  // signed load sum

  localparam logic [EW-1:0]        AccMax  = '1;
  localparam logic signed [LW-1:0] LoadMin = {2'b11, {(LOAD_BITS + 1){1'b0}}};

  logic [EW-1:0]        e_sum;
  logic [EW-1:0]        l_sum;
  logic                 win_fail;
  logic                 wait_br;
  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] d_full;
  logic signed [WW-1:0] w_full;
  logic                 dur_fail;
  logic signed [LW-1:0] ld_sum;
  logic signed [LW-1:0] ld_clamp;
  logic                 cap_fail;
  logic [TIME_BITS:0]   dist_sum;
  fail_t                reason;

  assign e_sum    = EW'(earliest) + EW'(leg_time);
  assign l_sum    = EW'(latest) + EW'(leg_time);
  assign win_fail = e_sum > EW'(window_close);
  assign wait_br  = !win_fail && (l_sum < EW'(window_open));

  // Wait = open - earliest arrival; negative when the interval is inverted.
  assign delta = $signed(DW'(window_open)) - $signed(DW'(e_sum));

  // With waiting, travel time cancels: duration + open - earliest.
  assign d_full = wait_br
                ? $signed(DW'(duration)) + $signed(DW'(window_open)) - $signed(DW'(earliest))
                : $signed(DW'(duration)) + $signed(DW'(leg_time));

  assign dur_fail = d_full[DW-1] || (d_full > $signed(DW'(max_duration)));

  assign w_full = $signed(WW'(wait_acc)) + {{(WW - DW){delta[DW-1]}}, delta};

  always_comb begin
    if (!wait_br) begin
      wait_upd = wait_acc;
    end else if (w_full[WW-1] || (w_full > $signed(WW'(AccMax)))) begin
      wait_upd = AccMax;
    end else begin
      wait_upd = w_full[EW-1:0];
    end
  end

  always_comb begin
    if (wait_br) begin
      earliest_upd = window_open;
      latest_upd   = window_open;
    end else begin
      earliest_upd = (EW'(window_open) > e_sum) ? window_open : e_sum[TIME_BITS-1:0];
      latest_upd   = (EW'(window_close) < l_sum) ? window_close : l_sum[TIME_BITS-1:0];
    end
  end

  assign duration_upd = d_full[TIME_BITS-1:0];

  assign dist_sum     = (TIME_BITS + 1)'(distance) + (TIME_BITS + 1)'(leg_distance);
  assign distance_upd = dist_sum[TIME_BITS] ? '1 : dist_sum[TIME_BITS-1:0];

  assign ld_sum   = {load[LOAD_BITS+1], load} + {{3{node_demand[LOAD_BITS-1]}}, node_demand};
  assign ld_clamp = (ld_sum < LoadMin) ? LoadMin : ld_sum;
  assign cap_fail = ld_clamp > $signed(LW'(vehicle_capacity));
  assign load_upd = ld_clamp[LOAD_BITS+1:0];
  assign peak_upd = (ld_clamp > $signed(LW'(peak))) ? ld_clamp[LOAD_BITS-1:0] : peak;

  always_comb begin
    if (fail_in != FAIL_NONE) begin
      reason = fail_in;
    end else if (dur_fail) begin
      reason = FAIL_DURATION;
    end else if (win_fail) begin
      reason = FAIL_WINDOW;
    end else if (cap_fail) begin
      reason = FAIL_CAPACITY;
    end else begin
      reason = FAIL_NONE;
    end
  end

  assign status.ok     = (reason == FAIL_NONE);
  assign status.reason = reason;

endmodule

### sim/testbench.sv
// Self-checking bench for route_time_window_evaluator_unit: streams route legs,
// predicts every route verdict with a behavioral model and checks each result transfer.
// Depends on rtwe_pkg and the top-level RTL only.
module testbench;
  import rtwe_pkg::*;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 144;
  localparam int STALL_LIMIT = 3000;
  localparam longint unsigned TMASK   = 64'hFF_FFFF;
  localparam longint unsigned ACC_SAT = 64'h3FF_FFFF;
  localparam longint LOAD_FLOOR = -64'sd131072;

  typedef struct {
    logic [23:0]        travel;
    logic [23:0]        service;
    logic signed [15:0] demand;
    logic [23:0]        w_open;
    logic [23:0]        w_close;
    logic               last;
  } leg_t;

  typedef struct packed {
    logic        feasible;
    fail_t       reason;
    logic [24:0] start_min;
    logic [24:0] start_max;
    logic [23:0] duration;
    logic [23:0] distance;
    logic [23:0] waiting;
    logic [15:0] peak;
  } route_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [23:0]           cfg_wdata = '0;

  route_time_window_evaluator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // route evaluator copy: configuration and per-route state
  longint unsigned dep_open, dep_close, dur_limit;
  longint          cap_limit;
  longint unsigned arr_early, arr_late, dur_sum, dist_sum, wait_sum;
  longint          load_now, load_max;
  fail_t           route_fail;

  route_result_t route_verdicts[$];
  route_result_t want;
  int send_idle = 0;
  int ready_stall = 0;
  int legs_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int verdict_tally[4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned sat26(input longint unsigned v);
    return (v > ACC_SAT) ? ACC_SAT : v;
  endfunction

  function automatic longint unsigned sat24(input longint unsigned v);
    return (v > TMASK) ? TMASK : v;
  endfunction

  function automatic void reload_depot();
    arr_early  = dep_open;
    arr_late   = dep_close;
    dur_sum    = 0;
    dist_sum   = 0;
    wait_sum   = 0;
    load_now   = 0;
    load_max   = 0;
    route_fail = FAIL_NONE;
  endfunction

  // Advances the route state by one leg; returns 1 with the verdict on a last leg.
  function automatic bit predict_leg(input leg_t leg, output route_result_t res);
    longint unsigned hop, e, l, d, w;
    longint ld;
    bit win_bad;
    res = '0;
    if (route_fail == FAIL_NONE) begin
      hop = leg.travel;
      hop += leg.service;
      e = arr_early + hop;
      l = arr_late + hop;
      d = dur_sum + hop;
      w = wait_sum;
      win_bad = 1'b0;
      ld = load_now + leg.demand;
      if (e > leg.w_close) begin
        win_bad = 1'b1;
      end else if (l < leg.w_open) begin
        // whole interval is early: wait for the window, 64-bit wrap if inverted
        d = d + (leg.w_open - e);
        w = w + (leg.w_open - e);
        e = leg.w_open;
        l = leg.w_open;
      end else begin
        if (leg.w_open > e) e = leg.w_open;
        if (leg.w_close < l) l = leg.w_close;
      end
      if (ld < LOAD_FLOOR) ld = LOAD_FLOOR;
      if (d > dur_limit) begin
        route_fail = FAIL_DURATION;
      end else if (win_bad) begin
        route_fail = FAIL_WINDOW;
      end else if (ld > cap_limit) begin
        route_fail = FAIL_CAPACITY;
      end else begin
        arr_early = sat26(e);
        arr_late  = sat26(l);
        dur_sum   = sat26(d);
        wait_sum  = sat26(w);
        dist_sum  = sat26(dist_sum + leg.travel);
        load_now  = ld;
        if (ld > 0 && ld > load_max) load_max = ld;
      end
    end
    if (!leg.last) return 1'b0;
    if (route_fail != FAIL_NONE) begin
      res.reason = route_fail;
    end else begin
      res.feasible  = 1'b1;
      res.start_min = 25'(arr_early - dur_sum);
      res.start_max = 25'(arr_late - dur_sum);
      res.duration  = 24'(sat24(dur_sum));
      res.distance  = 24'(sat24(dist_sum));
      res.waiting   = 24'(sat24(wait_sum));
      res.peak      = (load_max > 65535) ? 16'hFFFF : 16'(load_max);
    end
    reload_depot();
    return 1'b1;
  endfunction

  function automatic leg_t leg_of(input longint unsigned travel, input longint unsigned serv,
                                  input int demand, input longint unsigned w_o,
                                  input longint unsigned w_c, input bit last);
    leg_t leg;
    leg.travel  = 24'(travel);
    leg.service = 24'(serv);
    leg.demand  = 16'(demand);
    leg.w_open  = 24'(w_o);
    leg.w_close = 24'(w_c);
    leg.last    = last;
    return leg;
  endfunction

  // Mostly legs whose window sits near the current arrival time, so routes get deep.
  function automatic leg_t make_leg(input bit last, input bit wild);
    leg_t leg;
    longint unsigned reach, lo, hi, span;
    leg.last = last;
    if (wild) begin
      leg.travel  = 24'($urandom);
      leg.service = 24'($urandom);
      leg.demand  = 16'($urandom);
      leg.w_open  = 24'($urandom);
      leg.w_close = 24'($urandom);
      return leg;
    end
    leg.travel  = 24'($urandom_range(300));
    leg.service = 24'($urandom_range(60));
    leg.demand  = ($urandom_range(19) == 0) ? 16'($urandom) :
                  16'(int'($urandom_range(450)) - 150);
    reach = arr_early + leg.travel + leg.service;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        span = $urandom_range(200);
        lo = (reach > span) ? reach - span : 0;
        hi = reach + $urandom_range(3000);
      end
      6, 7: begin
        lo = reach + 1 + $urandom_range(500);
        hi = lo + $urandom_range(2000);
      end
      8: begin
        span = $urandom_range(100, 1);
        hi = (reach > span) ? reach - span : 0;
        lo = (hi > 50) ? hi - 50 : 0;
      end
      default: begin
        lo = $urandom_range(24'hFF_FFFF);
        hi = $urandom_range(24'hFF_FFFF);
      end
    endcase
    leg.w_open  = 24'(sat24(lo));
    leg.w_close = 24'(sat24(hi));
    return leg;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatch_count < 200)
      $display("route verdict %0d, %s: got 0x%0h, want 0x%0h", results_seen, what, got,
               exp_val);
    mismatch_count++;
  endtask

  // Called and returns at a falling edge; predicts on the accepting rising edge.
  task automatic send_leg(input leg_t leg);
    route_result_t verdict;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {leg.w_close, leg.w_open, leg.demand, leg.service, leg.travel};
    in_tlast  <= leg.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_leg(leg, verdict)) route_verdicts.push_back(verdict);
    legs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (route_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    cfg_index <= idx;
    cfg_wdata <= 24'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEPOT_OPEN:       dep_open  = val & TMASK;
      CFG_DEPOT_CLOSE:      dep_close = val & TMASK;
      CFG_MAX_DURATION:     dur_limit = val & TMASK;
      CFG_VEHICLE_CAPACITY: cap_limit = longint'(val & 64'hFFFF);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Depot values take effect only once the current route has been reloaded.
  task automatic write_config(input longint unsigned open_v, input longint unsigned close_v,
                              input longint unsigned dur_v, input longint unsigned cap_v);
    drain_results();
    repeat (4) @(negedge clk);  // legs without tlast may still be in the pipe
    put_reg(CFG_DEPOT_OPEN, open_v);
    put_reg(CFG_DEPOT_CLOSE, close_v);
    put_reg(CFG_MAX_DURATION, dur_v);
    put_reg(CFG_VEHICLE_CAPACITY, cap_v);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_routes(input int n_legs);
    int sent;
    int route_len;
    sent = 0;
    while (sent < n_legs) begin
      route_len = ($urandom_range(15) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
      for (int k = 0; k < route_len; k++)
        send_leg(make_leg(k == route_len - 1, $urandom_range(9) == 0));
      sent += route_len;
      // hold off now and then until every route verdict is back
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  task automatic test_route_basics();
    send_leg(leg_of(0, 0, 0, 0, 0, 1));
    send_leg(leg_of(TMASK, TMASK, 0, 0, TMASK, 1));  // duration and window both fail
    send_leg(leg_of(100, 0, 0, 0, 50, 1));           // arrives after close
    send_leg(leg_of(0, 0, 0, TMASK, TMASK, 1));      // window opens at depot close: no wait, start pinned to close
  endtask

  task automatic test_window_forms();
    send_leg(leg_of(10, 5, -32768, 1000, 2000, 0));
    send_leg(leg_of(20, 0, 32767, 0, TMASK, 1));
    send_leg(leg_of(10, 0, 5, 500, 100, 0));         // open above close
    send_leg(leg_of(1, 1, 0, 0, TMASK, 1));
  endtask

  task automatic test_load_limits();
    repeat (2) send_leg(leg_of(1, 0, 32767, 0, TMASK, 0));
    send_leg(leg_of(1, 0, 32767, 0, TMASK, 1));
    repeat (5) send_leg(leg_of(0, 1, -32768, 0, TMASK, 0));  // load hits its floor
    send_leg(leg_of(0, 1, 32767, 0, TMASK, 1));
  endtask

  task automatic test_failed_route_hold();
    send_leg(leg_of(TMASK, TMASK, 0, 0, TMASK, 0));
    send_leg(leg_of(5, 5, 10, 0, TMASK, 0));
    send_leg(leg_of(1, 1, 1, 0, TMASK, 1));
  endtask

  task automatic test_config_extremes();
    write_config(0, 0, 0, 0);
    send_routes(15);
    write_config(TMASK, 0, TMASK, 0);
    send_routes(15);
    write_config(TMASK, TMASK, TMASK, 16'hFFFF);
    send_routes(15);
    write_config(0, TMASK, TMASK, 16'hFFFF);
    send_routes(15);
  endtask

  task automatic run_random_phase(input int n_legs, input int idle_pct, input int stall_pct);
    longint unsigned open_v, close_v, dur_v, cap_v;
    send_idle   = idle_pct;
    ready_stall = stall_pct;
    for (int seg = 0; seg < 3; seg++) begin
      open_v  = $urandom_range(3000);
      close_v = ($urandom_range(9) == 0) ? $urandom_range(3000) :
                open_v + $urandom_range(60000);
      dur_v   = ($urandom_range(7) == 0) ? TMASK : $urandom_range(40000, 1500);
      cap_v   = ($urandom_range(7) == 0) ? 65535 : $urandom_range(3000, 100);
      write_config(open_v, close_v, dur_v, cap_v);
      send_routes(n_legs / 3);
    end
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= ready_stall);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (route_verdicts.size() == 0) begin
        report_mismatch("result with no route pending", {61'b0, out_tuser}, 64'b0);
      end else begin
        want = route_verdicts.pop_front();
        verdict_tally[want.reason]++;
        if (out_tuser[0] !== want.feasible)
          report_mismatch("feasible", out_tuser[0], want.feasible);
        if (out_tuser[2:1] !== want.reason)
          report_mismatch("fail_reason", out_tuser[2:1], want.reason);
        if (out_tdata[24:0] !== want.start_min)
          report_mismatch("depot_earliest_start", out_tdata[24:0], want.start_min);
        if (out_tdata[49:25] !== want.start_max)
          report_mismatch("depot_latest_start", out_tdata[49:25], want.start_max);
        if (out_tdata[73:50] !== want.duration)
          report_mismatch("route duration", out_tdata[73:50], want.duration);
        if (out_tdata[97:74] !== want.distance)
          report_mismatch("route distance", out_tdata[97:74], want.distance);
        if (out_tdata[121:98] !== want.waiting)
          report_mismatch("wait_total", out_tdata[121:98], want.waiting);
        if (out_tdata[137:122] !== want.peak)
          report_mismatch("peak_load", out_tdata[137:122], want.peak);
      end
    end
  end

  // Ends a hung run: no transfer on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d verdicts outstanding",
               idle_cycles, route_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dep_open  = 0;
    dep_close = TMASK;
    dur_limit = TMASK;
    cap_limit = 65535;
    reload_depot();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_route_basics();
    test_window_forms();
    test_load_limits();
    test_failed_route_hold();
    test_config_extremes();
    run_random_phase(340, 0, 0);
    run_random_phase(340, 86, 0);
    run_random_phase(340, 0, 86);
    run_random_phase(340, 19, 19);
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d legs sent through directed, config-extreme and four pressure phases;",
             legs_sent);
    $display("%0d verdicts checked: feasible %0d, duration %0d, window %0d, capacity %0d",
             results_seen, verdict_tally[FAIL_NONE], verdict_tally[FAIL_DURATION],
             verdict_tally[FAIL_WINDOW], verdict_tally[FAIL_CAPACITY]);
    if (mismatch_count == 0 && route_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
